// ----- src/fhcu_pkg.sv -----
// Package for the flame heat column update block.
// Holds the channel word types, the state machine type and the palette and
// divide-by-three helpers. No dependencies.
package fhcu_pkg;

  typedef struct packed {
    logic [3:0] column;
    logic [4:0] row;
    logic [7:0] cool_amount;
    logic [7:0] spark_heat;
  } fhcu_in_t;

  typedef struct packed {
    logic [3:0] out_column;
    logic [4:0] out_row;
    logic [7:0] new_heat;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } fhcu_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } fhcu_rgb_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } fhcu_state_t;

  // Palette scale (192/256) and ramp bit layout.
  localparam logic [7:0] PAL_HOT_BIT  = 8'h80;
  localparam logic [7:0] PAL_WARM_BIT = 8'h40;
  localparam logic [7:0] PAL_RAMP_MSK = 8'h3F;
  localparam logic [7:0] CHAN_FULL    = 8'hFF;

  // floor(n/3) = (n * 683) >> 11, exact for n below 2048.
  localparam logic [10:0] RECIP3       = 11'd683;
  localparam int          RECIP3_SHIFT = 11;

  function automatic logic [7:0] div3(input logic [9:0] n);
    logic [20:0] prod;
    prod = 21'(n) * 21'(RECIP3);
    return prod[RECIP3_SHIFT +: 8];
  endfunction

  function automatic fhcu_rgb_t heat_palette(input logic [7:0] heat);
    logic [15:0] scaled;
    logic [7:0]  t;
    logic [7:0]  ramp;
    fhcu_rgb_t   c;
    // heat * 192 as two shifted copies
    scaled = (16'(heat) << 7) + (16'(heat) << 6);
    t      = scaled[15:8] + 8'(heat != 8'd0);
    ramp   = (t & PAL_RAMP_MSK) << 2;
    if ((t & PAL_HOT_BIT) != 8'd0) begin
      c = '{red: CHAN_FULL, green: CHAN_FULL, blue: ramp};
    end else if ((t & PAL_WARM_BIT) != 8'd0) begin
      c = '{red: CHAN_FULL, green: ramp, blue: 8'd0};
    end else begin
      c = '{red: ramp, green: 8'd0, blue: 8'd0};
    end
    return c;
  endfunction

endpackage

// ----- src/fhcu_ifs.sv -----
// Valid/ready channel interfaces for the flame heat column update block.
// Depends on fhcu_pkg for the word types.
interface fhcu_in_if;
  logic               valid;
  logic               ready;
  fhcu_pkg::fhcu_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface fhcu_out_if;
  logic                valid;
  logic                ready;
  fhcu_pkg::fhcu_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/fhcu_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// Read during a write to the same address returns the old contents.
// No dependencies.
module fhcu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold the last read word while no read is issued
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/flame_heat_column_update.sv -----
// Flame heat column update: heat store RAM, cooling, column averaging, palette.
// Depends on fhcu_pkg, fhcu_ifs (channel interfaces) and fhcu_ram.
//
//   channel   dir  word                                            handshake
//   in_chan   in   column, row, cool_amount, spark_heat            valid/ready
//   out_chan  out  out_column, out_row, new_heat, red, green, blue valid/ready
//
// One word per cycle unless out_chan stalls; stage 1 feeds the output register.
// Stage 0 issues the heat store read, stage 1 cools, averages, writes back and
// loads the output register; a same-cell write in the accept cycle is forwarded.
// After reset the store is swept to zero, address by address, with in_chan.ready low.
// A stalled output holds stage 1, which holds in_chan.ready low once stage 1 is full.
module flame_heat_column_update #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 32
) (
  input logic        clk,
  input logic        rst_n,
  fhcu_in_if.sink    in_chan,
  fhcu_out_if.source out_chan
);
  import fhcu_pkg::*;

  localparam int DEPTH = COLUMNS * ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IDXW  = (AW > 13) ? AW : 13;

  fhcu_state_t st_r, st_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          clearing;

  logic          in_fire;
  logic [IDXW-1:0] in_idx;
  logic [AW-1:0] in_addr;
  logic          in_inside;

  logic          s1_valid_r;
  fhcu_in_t      s1_item_r;
  logic [AW-1:0] s1_addr_r;
  logic          s1_inside_r;
  logic          s1_fire;
  logic          fwd_r;
  logic [7:0]    fwd_heat_r;

  logic [7:0]    cool_one_r, cool_two_r, cool_three_r;
  logic [7:0]    stored, cooled, heat;
  fhcu_rgb_t     rgb;

  logic          out_valid_r;
  fhcu_out_t     out_word_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  // ---------------------------------------------------------------- clear sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      st_r      <= st_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_comb begin
    st_nxt      = st_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (st_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          st_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        clr_cnt_nxt = clr_cnt_r;
      end
      default: st_nxt = ST_CLEAR;
    endcase
  end

  assign clearing = (st_r == ST_CLEAR);

  // ---------------------------------------------------------------- stage 0
  assign s1_fire        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !clearing && (!s1_valid_r || s1_fire);
  assign in_fire        = in_chan.valid && in_chan.ready;

  assign in_idx    = IDXW'(in_chan.payload.column) * IDXW'(ROWS)
                   + IDXW'(in_chan.payload.row);
  assign in_addr   = in_idx[AW-1:0];
  assign in_inside = (int'(in_chan.payload.column) < COLUMNS)
                  && (int'(in_chan.payload.row) < ROWS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r   <= in_chan.payload;
      s1_addr_r   <= in_addr;
      s1_inside_r <= in_inside;
      // catch the write that lands in the same cycle as this read
      fwd_r       <= s1_fire && s1_inside_r && in_inside && (s1_addr_r == in_addr);
      fwd_heat_r  <= heat;
    end
  end

  // ---------------------------------------------------------------- stage 1
  assign stored = fwd_r ? fwd_heat_r : (s1_inside_r ? ram_rdata : 8'd0);
  assign cooled = (stored > s1_item_r.cool_amount) ? (stored - s1_item_r.cool_amount)
                                                   : 8'd0;

  always_comb begin
    priority if (s1_item_r.row == 5'd0) begin
      heat = s1_item_r.spark_heat;
    end else if (s1_item_r.row == 5'd1) begin
      heat = cool_one_r;
    end else if (s1_item_r.row == 5'd2) begin
      heat = 8'((9'(cool_one_r) + 9'(cool_two_r)) >> 1);
    end else begin
      heat = div3(10'(cool_one_r) + 10'(cool_two_r) + 10'(cool_three_r));
    end
  end

  assign rgb = heat_palette(heat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cool_one_r   <= 8'd0;
      cool_two_r   <= 8'd0;
      cool_three_r <= 8'd0;
    end else if (s1_fire) begin
      cool_three_r <= cool_two_r;
      cool_two_r   <= cool_one_r;
      cool_one_r   <= cooled;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_word_r <= '{out_column: s1_item_r.column, out_row: s1_item_r.row,
                      new_heat: heat, red: rgb.red, green: rgb.green,
                      blue: rgb.blue};
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_word_r;

  // ---------------------------------------------------------------- heat store
  assign ram_we    = clearing || (s1_fire && s1_inside_r);
  assign ram_waddr = clearing ? clr_cnt_r : s1_addr_r;
  assign ram_wdata = clearing ? 8'd0 : heat;

  fhcu_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_heat_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- checks
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_chan.ready)
    else $error("word accepted during clear sweep");

  a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |=> s1_valid_r)
    else $error("stage 1 word lost while stalled");

  a_fire_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r && (out_word_r.new_heat == $past(heat)))
    else $error("output register missed a finished word");

  a_cool_shift: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> (cool_two_r == $past(cool_one_r)) && (cool_three_r == $past(cool_two_r)))
    else $error("cooled history did not advance");

  a_row1_takes_below: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_item_r.row == 5'd1) |=> (out_word_r.new_heat == $past(cool_one_r)))
    else $error("row 1 heat differs from cooled row below");

endmodule
